>>> rtl/i2cms_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package i2cms_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_EVENT  = 2'd1,
    OP_SUPPLY = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  // Commands to the byte-level engine
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_e;

  // Transaction error codes
  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_START   = 3'd1,
    ERR_ADDR    = 3'd2,
    ERR_BYTE    = 3'd3,
    ERR_BUSY    = 3'd4
  } err_e;

  // Engine status codes, compared after masking
  localparam logic [7:0] STATUS_MASK     = 8'hF8;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
  localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

  localparam int unsigned MAX_REG_BYTES = 2;

  // Classified item as queued between front and back
  typedef struct packed {
    op_e         kind;
    logic        is_read;
    logic [1:0]  reg_bytes;   // clamped to MAX_REG_BYTES
    logic [6:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [7:0]  count;       // read count of zero already raised to one
    logic [7:0]  status;      // masked engine status
    logic [7:0]  data;        // write byte on supply, received byte on event
  } item_t;

  // One result item
  typedef struct packed {
    cmd_e        engine_cmd;
    logic [7:0]  cmd_byte;
    logic        need_write_byte;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        read_last;
    logic        done_res;
    err_e        error_code;
  } res_t;

  // Queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> rtl/i2cms_front.sv
// Input side of the sequencer: accepts stream items and classifies them.
// Depends on i2cms_pkg; feeds the item queue.
`timescale 1ns / 1ps

module i2cms_front (
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [63:0]            s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  input  i2cms_pkg::fifo_stat_t  q_stat_i,
  output logic                   push_o,
  output i2cms_pkg::item_t       push_item_o
);

  logic        is_read;
  logic [1:0]  reg_bytes;
  logic [7:0]  count;
  logic [7:0]  status;
  logic [7:0]  rx_byte;
  logic [7:0]  wr_byte;

  // Take items whenever the queue has room
  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && !q_stat_i.full;

  // Unpack fields
  assign is_read   = s_axis_tdata[0];
  assign reg_bytes = s_axis_tdata[2:1];
  assign count     = s_axis_tdata[33:26];
  assign status    = s_axis_tdata[41:34];
  assign rx_byte   = s_axis_tdata[49:42];
  assign wr_byte   = s_axis_tdata[57:50];

  // Classify: clamp register bytes, raise an empty read, mask status, pick data byte
  always_comb begin
    push_item_o.kind      = i2cms_pkg::op_e'(s_axis_tuser);
    push_item_o.is_read   = is_read;
    push_item_o.reg_bytes = (reg_bytes > 2'(i2cms_pkg::MAX_REG_BYTES)) ?
                            2'(i2cms_pkg::MAX_REG_BYTES) : reg_bytes;
    push_item_o.dev_addr  = s_axis_tdata[9:3];
    push_item_o.reg_addr  = s_axis_tdata[25:10];
    push_item_o.count     = (is_read && count == 8'd0) ? 8'd1 : count;
    push_item_o.status    = status & i2cms_pkg::STATUS_MASK;
    push_item_o.data      = (i2cms_pkg::op_e'(s_axis_tuser) == i2cms_pkg::OP_SUPPLY) ?
                            wr_byte : rx_byte;
  end

endmodule

>>> rtl/i2cms_fifo.sv
// Short item queue between the front and the back of the sequencer.
// Depends on i2cms_pkg for the item and status types.
`timescale 1ns / 1ps

module i2cms_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  i2cms_pkg::item_t       push_item_i,
  input  logic                   pop_i,
  output i2cms_pkg::item_t       pop_item_o,
  output i2cms_pkg::fifo_stat_t  stat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  i2cms_pkg::item_t  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !pop_i)
    else $error("queue read while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on write");

endmodule

>>> rtl/i2cms_back.sv
// Back end of the sequencer: transaction state machine and output register.
// Depends on i2cms_pkg; pops classified items from the queue.
`timescale 1ns / 1ps

module i2cms_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2cms_pkg::fifo_stat_t  q_stat_i,
  input  i2cms_pkg::item_t       item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output i2cms_pkg::res_t        res_o
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_SLA_W   = 4'd2,
    PH_REG     = 4'd3,
    PH_SUPPLY  = 4'd4,
    PH_DATA    = 4'd5,
    PH_RESTART = 4'd6,
    PH_SLA_R   = 4'd7,
    PH_RX      = 4'd8
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             read_mode_q, read_mode_d;
  logic [1:0]       rbl_q, rbl_d;
  logic [6:0]       tgt_q, tgt_d;
  logic [15:0]      raddr_q, raddr_d;
  logic [7:0]       left_q, left_d;
  logic             out_valid_q, out_valid_d;
  i2cms_pkg::res_t  res_q, res_d;
  logic             out_free;
  logic             start_ok;
  logic [7:0]       sla_w, sla_r;
  logic [7:0]       reg_byte;
  logic [7:0]       rx_expect;
  logic [7:0]       left_dec;

  // Pop one item whenever the output register is free or being drained
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = !q_stat_i.empty && out_free;

  assign sla_w     = {tgt_q, 1'b0};
  assign sla_r     = {tgt_q, 1'b1};
  assign start_ok  = (item_i.status == i2cms_pkg::ST_START) ||
                     (item_i.status == i2cms_pkg::ST_REP_START);
  assign reg_byte  = (rbl_q == 2'd2) ? raddr_q[15:8] : raddr_q[7:0];
  assign rx_expect = (left_q > 8'd1) ? i2cms_pkg::ST_DATA_RX_ACK : i2cms_pkg::ST_DATA_RX_NACK;
  assign left_dec  = (left_q == 8'd0) ? 8'd0 : left_q - 8'd1;

  // Next transaction state and result for the popped item
  always_comb begin
    phase_d     = phase_q;
    read_mode_d = read_mode_q;
    rbl_d       = rbl_q;
    tgt_d       = tgt_q;
    raddr_d     = raddr_q;
    left_d      = left_q;
    res_d       = '0;
    if (item_i.kind == i2cms_pkg::OP_BEGIN && phase_q == PH_IDLE) begin
      read_mode_d      = item_i.is_read;
      rbl_d            = item_i.reg_bytes;
      tgt_d            = item_i.dev_addr;
      raddr_d          = item_i.reg_addr;
      left_d           = item_i.count;
      res_d.engine_cmd = i2cms_pkg::CMD_START;
      phase_d          = PH_START;
    end else if (item_i.kind == i2cms_pkg::OP_SUPPLY && phase_q == PH_SUPPLY) begin
      left_d           = left_q - 8'd1;
      res_d.engine_cmd = i2cms_pkg::CMD_SEND;
      res_d.cmd_byte   = item_i.data;
      phase_d          = PH_DATA;
    end else if (item_i.kind != i2cms_pkg::OP_EVENT || phase_q == PH_IDLE ||
                 phase_q == PH_SUPPLY) begin
      // Misplaced item: report busy, leave state alone
      res_d.error_code = i2cms_pkg::ERR_BUSY;
    end else begin
      case (phase_q)
        PH_START: begin
          if (!start_ok) begin
            phase_d = PH_IDLE; res_d.done_res = 1'b1; res_d.error_code = i2cms_pkg::ERR_START;
          end else if (read_mode_q && rbl_q == 2'd0) begin
            res_d.engine_cmd = i2cms_pkg::CMD_SEND; res_d.cmd_byte = sla_r; phase_d = PH_SLA_R;
          end else begin
            res_d.engine_cmd = i2cms_pkg::CMD_SEND; res_d.cmd_byte = sla_w; phase_d = PH_SLA_W;
          end
        end
        PH_SLA_W, PH_REG, PH_DATA: begin
          if (phase_q == PH_SLA_W && item_i.status != i2cms_pkg::ST_SLA_W_ACK) begin
            phase_d = PH_IDLE; res_d.done_res = 1'b1; res_d.error_code = i2cms_pkg::ERR_ADDR;
          end else if (phase_q != PH_SLA_W && item_i.status != i2cms_pkg::ST_DATA_TX_ACK) begin
            phase_d = PH_IDLE; res_d.done_res = 1'b1; res_d.error_code = i2cms_pkg::ERR_BYTE;
          end else if (phase_q != PH_DATA && rbl_q != 2'd0) begin
            // Next register address byte, high first
            res_d.engine_cmd = i2cms_pkg::CMD_SEND;
            res_d.cmd_byte   = reg_byte;
            rbl_d            = rbl_q - 2'd1;
            phase_d          = PH_REG;
          end else if (phase_q == PH_REG && read_mode_q) begin
            res_d.engine_cmd = i2cms_pkg::CMD_START;
            phase_d          = PH_RESTART;
          end else if (left_q != 8'd0) begin
            res_d.need_write_byte = 1'b1;
            phase_d               = PH_SUPPLY;
          end else begin
            res_d.engine_cmd = i2cms_pkg::CMD_STOP;
            res_d.done_res   = 1'b1;
            phase_d          = PH_IDLE;
          end
        end
        PH_RESTART: begin
          if (!start_ok) begin
            phase_d = PH_IDLE; res_d.done_res = 1'b1; res_d.error_code = i2cms_pkg::ERR_START;
          end else begin
            res_d.engine_cmd = i2cms_pkg::CMD_SEND; res_d.cmd_byte = sla_r; phase_d = PH_SLA_R;
          end
        end
        PH_SLA_R: begin
          if (item_i.status != i2cms_pkg::ST_SLA_R_ACK) begin
            phase_d = PH_IDLE; res_d.done_res = 1'b1; res_d.error_code = i2cms_pkg::ERR_ADDR;
          end else begin
            res_d.engine_cmd = (left_q > 8'd1) ? i2cms_pkg::CMD_RX_ACK : i2cms_pkg::CMD_RX_NACK;
            phase_d          = PH_RX;
          end
        end
        PH_RX: begin
          // Deliver the byte, zero on an unexpected status, then continue or stop
          res_d.read_valid = 1'b1;
          res_d.read_byte  = (item_i.status == rx_expect) ? item_i.data : 8'd0;
          left_d           = left_dec;
          if (left_dec == 8'd0) begin
            res_d.read_last  = 1'b1;
            res_d.engine_cmd = i2cms_pkg::CMD_STOP;
            res_d.done_res   = 1'b1;
            phase_d          = PH_IDLE;
          end else begin
            res_d.engine_cmd = (left_dec > 8'd1) ? i2cms_pkg::CMD_RX_ACK :
                               i2cms_pkg::CMD_RX_NACK;
          end
        end
        default: begin
          phase_d          = PH_IDLE;
          res_d.error_code = i2cms_pkg::ERR_BUSY;
        end
      endcase
    end
  end

  // Hold the output until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      read_mode_q <= 1'b0;
      rbl_q       <= '0;
      tgt_q       <= '0;
      raddr_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q     <= phase_d;
        read_mode_q <= read_mode_d;
        rbl_q       <= rbl_d;
        tgt_q       <= tgt_d;
        raddr_q     <= raddr_d;
        left_q      <= left_d;
        res_q       <= res_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res_d.done_res) |=> (phase_q == PH_IDLE))
    else $error("finished transaction did not return to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res_d.need_write_byte) |=> (phase_q == PH_SUPPLY))
    else $error("write byte requested without waiting for it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res_d.error_code == i2cms_pkg::ERR_BUSY) |=> $stable(phase_q))
    else $error("misplaced item changed the phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.done_res && res_q.error_code != i2cms_pkg::ERR_OK)
      |-> (res_q.engine_cmd == i2cms_pkg::CMD_NONE))
    else $error("failed transaction issued an engine command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.read_last)
      |-> (res_q.done_res && res_q.engine_cmd == i2cms_pkg::CMD_STOP))
    else $error("last read byte without stop");

endmodule

>>> rtl/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer: accepts one item per cycle while the queue
// has room and returns one result per item; the front classifies items into a
// FIFO_DEPTH-entry queue and the back state machine handles one queued item per
// cycle into a registered output, so the sustained rate is one item per clock
// while the output is taken. A begin item issues START, SLA+W and the register
// bytes, or SLA+R for a read with none; each engine completion event is checked
// against the status the current step expects, and a mismatch outside a receive
// ends the transaction with an error and no stop. Writes request each data byte
// with need_write_byte; reads with register bytes then send a repeated START
// and SLA+R; reads receive with ACK and the last byte with NACK.
// Depends on i2cms_pkg, i2cms_front, i2cms_fifo and i2cms_back.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // is_read[0], reg_bytes[2:1], device_address[9:3], reg_address[25:10],
  // byte_count[33:26], engine_status[41:34], engine_rx_byte[49:42],
  // write_byte[57:50], zeros above
  input  logic [63:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cmd_byte[7:0], need_write_byte[8], read_valid[9], read_byte[17:10],
  // done_res[18], error_code[21:19], zeros above
  output logic [23:0] m_axis_tdata,
  // engine_cmd[2:0]
  output logic [2:0]  m_axis_tuser,
  // read_last
  output logic        m_axis_tlast
);

  i2cms_pkg::fifo_stat_t  q_stat;
  i2cms_pkg::item_t       push_item;
  i2cms_pkg::item_t       pop_item;
  i2cms_pkg::res_t        res;
  logic                   push;
  logic                   pop;

  i2cms_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  i2cms_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  i2cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result item
  assign m_axis_tdata = {2'b00, res.error_code, res.done_res, res.read_byte,
                         res.read_valid, res.need_write_byte, res.cmd_byte};
  assign m_axis_tuser = res.engine_cmd;
  assign m_axis_tlast = res.read_last;

endmodule

>>> tb/i2cms_result_checker.sv
// Result checker for the I2C master transaction sequencer: watches both stream
// channels, predicts one result per accepted item and compares in order.
// Depends on i2cms_pkg for the item kinds, commands, error codes and status codes.
`timescale 1ns / 1ps

module i2cms_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // is_read[0], reg_bytes[2:1], device_address[9:3], reg_address[25:10],
  // byte_count[33:26], engine_status[41:34], engine_rx_byte[49:42],
  // write_byte[57:50], zeros above
  input  logic [63:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cmd_byte[7:0], need_write_byte[8], read_valid[9], read_byte[17:10],
  // done_res[18], error_code[21:19], zeros above
  input  logic [23:0] m_axis_tdata,
  // engine_cmd[2:0]
  input  logic [2:0]  m_axis_tuser,
  // read_last
  input  logic        m_axis_tlast,
  output int          err_count_o,
  output int          pending_o
);

  typedef enum logic [3:0] {
    IDLE,
    AWAIT_START,
    AWAIT_SLA_W,
    AWAIT_REG,
    AWAIT_SUPPLY,
    AWAIT_DATA,
    AWAIT_RESTART,
    AWAIT_SLA_R,
    AWAIT_RX
  } seq_phase_e;

  seq_phase_e  phase;
  logic        rd_mode;
  logic [1:0]  reg_left;
  logic [6:0]  tgt_addr;
  logic [15:0] reg_addr;
  logic [7:0]  bytes_left;

  i2cms_pkg::res_t predicted_results[$];
  int              mismatches;

  // End the transaction with an error and no stop
  task automatic abort_txn(inout i2cms_pkg::res_t r, input i2cms_pkg::err_e code);
    phase        = IDLE;
    r.done_res   = 1'b1;
    r.error_code = code;
  endtask

  task automatic send_byte(inout i2cms_pkg::res_t r, input logic [7:0] b,
                           input seq_phase_e nxt);
    r.engine_cmd = i2cms_pkg::CMD_SEND;
    r.cmd_byte   = b;
    phase        = nxt;
  endtask

  // Register address goes out high byte first
  task automatic send_reg_byte(inout i2cms_pkg::res_t r);
    logic [7:0] b;
    b = (reg_left == 2'd2) ? reg_addr[15:8] : reg_addr[7:0];
    reg_left = reg_left - 2'd1;
    send_byte(r, b, AWAIT_REG);
  endtask

  // Ask for the next data byte, or stop when none is left
  task automatic continue_write(inout i2cms_pkg::res_t r);
    if (bytes_left != 8'd0) begin
      r.need_write_byte = 1'b1;
      phase = AWAIT_SUPPLY;
    end else begin
      r.engine_cmd = i2cms_pkg::CMD_STOP;
      r.done_res   = 1'b1;
      phase        = IDLE;
    end
  endtask

  task automatic request_rx(inout i2cms_pkg::res_t r);
    r.engine_cmd = (bytes_left > 8'd1) ? i2cms_pkg::CMD_RX_ACK : i2cms_pkg::CMD_RX_NACK;
    phase = AWAIT_RX;
  endtask

  // Advance the predicted sequencer by one item
  task automatic step_sequencer(input i2cms_pkg::op_e op, input logic [63:0] d,
                                output i2cms_pkg::res_t r);
    logic [7:0] st;
    logic [7:0] sla_w;
    logic [7:0] rx_code;
    logic       start_ok;
    st       = d[41:34] & i2cms_pkg::STATUS_MASK;
    sla_w    = {tgt_addr, 1'b0};
    start_ok = (st == i2cms_pkg::ST_START) || (st == i2cms_pkg::ST_REP_START);
    r        = '0;
    if (op == i2cms_pkg::OP_BEGIN && phase == IDLE) begin
      rd_mode    = d[0];
      reg_left   = (d[2:1] > 2'd2) ? 2'd2 : d[2:1];
      tgt_addr   = d[9:3];
      reg_addr   = d[25:10];
      bytes_left = d[33:26];
      if (rd_mode && bytes_left == 8'd0) bytes_left = 8'd1;
      r.engine_cmd = i2cms_pkg::CMD_START;
      phase = AWAIT_START;
    end else if (op == i2cms_pkg::OP_SUPPLY && phase == AWAIT_SUPPLY) begin
      bytes_left = bytes_left - 8'd1;
      send_byte(r, d[57:50], AWAIT_DATA);
    end else if (op != i2cms_pkg::OP_EVENT || phase == IDLE || phase == AWAIT_SUPPLY) begin
      r.error_code = i2cms_pkg::ERR_BUSY;
    end else begin
      case (phase)
        AWAIT_START: begin
          if (!start_ok) abort_txn(r, i2cms_pkg::ERR_START);
          else if (rd_mode && reg_left == 2'd0) send_byte(r, sla_w | 8'd1, AWAIT_SLA_R);
          else send_byte(r, sla_w, AWAIT_SLA_W);
        end
        AWAIT_SLA_W: begin
          if (st != i2cms_pkg::ST_SLA_W_ACK) abort_txn(r, i2cms_pkg::ERR_ADDR);
          else if (reg_left != 2'd0) send_reg_byte(r);
          else continue_write(r);
        end
        AWAIT_REG: begin
          if (st != i2cms_pkg::ST_DATA_TX_ACK) begin
            abort_txn(r, i2cms_pkg::ERR_BYTE);
          end else if (reg_left != 2'd0) begin
            send_reg_byte(r);
          end else if (rd_mode) begin
            r.engine_cmd = i2cms_pkg::CMD_START;
            phase = AWAIT_RESTART;
          end else begin
            continue_write(r);
          end
        end
        AWAIT_DATA: begin
          if (st != i2cms_pkg::ST_DATA_TX_ACK) abort_txn(r, i2cms_pkg::ERR_BYTE);
          else continue_write(r);
        end
        AWAIT_RESTART: begin
          if (!start_ok) abort_txn(r, i2cms_pkg::ERR_START);
          else send_byte(r, sla_w | 8'd1, AWAIT_SLA_R);
        end
        AWAIT_SLA_R: begin
          if (st != i2cms_pkg::ST_SLA_R_ACK) abort_txn(r, i2cms_pkg::ERR_ADDR);
          else request_rx(r);
        end
        AWAIT_RX: begin
          // A bad receive status zeroes the byte but the read goes on
          rx_code = (bytes_left > 8'd1) ? i2cms_pkg::ST_DATA_RX_ACK :
                                          i2cms_pkg::ST_DATA_RX_NACK;
          r.read_valid = 1'b1;
          r.read_byte  = (st == rx_code) ? d[49:42] : 8'd0;
          if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) begin
            r.read_last  = 1'b1;
            r.engine_cmd = i2cms_pkg::CMD_STOP;
            r.done_res   = 1'b1;
            phase        = IDLE;
          end else begin
            request_rx(r);
          end
        end
        default: begin
          phase = IDLE;
          r.error_code = i2cms_pkg::ERR_BUSY;
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Predict on input accept, compare on output accept
  always @(posedge clk_i or negedge rst_ni) begin
    i2cms_pkg::res_t pred;
    i2cms_pkg::res_t seen;
    if (!rst_ni) begin
      phase       = IDLE;
      rd_mode     = 1'b0;
      reg_left    = 2'd0;
      tgt_addr    = 7'd0;
      reg_addr    = 16'd0;
      bytes_left  = 8'd0;
      mismatches  = 0;
      err_count_o <= 0;
      pending_o   <= 0;
      predicted_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_sequencer(i2cms_pkg::op_e'(s_axis_tuser), s_axis_tdata, pred);
        predicted_results.push_back(pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.engine_cmd      = i2cms_pkg::cmd_e'(m_axis_tuser);
        seen.cmd_byte        = m_axis_tdata[7:0];
        seen.need_write_byte = m_axis_tdata[8];
        seen.read_valid      = m_axis_tdata[9];
        seen.read_byte       = m_axis_tdata[17:10];
        seen.read_last       = m_axis_tlast;
        seen.done_res        = m_axis_tdata[18];
        seen.error_code      = i2cms_pkg::err_e'(m_axis_tdata[21:19]);
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %h/%h/%b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          pred = predicted_results.pop_front();
          check_field("engine_cmd", pred.engine_cmd, seen.engine_cmd);
          check_field("cmd_byte", pred.cmd_byte, seen.cmd_byte);
          check_field("need_write_byte", pred.need_write_byte, seen.need_write_byte);
          check_field("read_valid", pred.read_valid, seen.read_valid);
          check_field("read_byte", pred.read_byte, seen.read_byte);
          check_field("read_last", pred.read_last, seen.read_last);
          check_field("done_res", pred.done_res, seen.done_res);
          check_field("error_code", pred.error_code, seen.error_code);
        end
      end
      err_count_o <= mismatches;
      pending_o   <= predicted_results.size();
    end
  end

endmodule

>>> tb/tb_i2c_master_transaction_sequencer.sv
// Testbench top for the I2C master transaction sequencer: drives directed and
// random transactions with misplaced items mixed in, and reports the verdict.
// Depends on i2cms_pkg, the sequencer RTL and i2cms_result_checker.
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer;

  typedef enum {CTX_IDLE, CTX_BUSY, CTX_SUPPLY} seq_ctx_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          err_count;
  int          pending;

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int err_pct      = 0;
  int rx_bad_pct   = 0;
  int noise_pct    = 0;
  int stim_items   = 0;

  always #5 clk_i = ~clk_i;

  i2c_master_transaction_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  i2cms_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // Stall the result channel at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Random payload; fields the item does not use stay random too
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[63:58] = '0;
    return w;
  endfunction

  // Hold one item until it is accepted, with random idle cycles ahead of it
  task automatic send_item(input i2cms_pkg::op_e op, input logic [63:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    stim_items++;
  endtask

  // Send one item of a sequence, sometimes after an item that is out of place
  task automatic issue(input i2cms_pkg::op_e op, input logic [63:0] d,
                       input seq_ctx_e ctx);
    int pick;
    if ($urandom_range(99) < noise_pct) begin
      pick = $urandom_range(2);
      if (pick == 2) send_item(i2cms_pkg::OP_BAD, rand_word());
      else case (ctx)
        CTX_IDLE:   send_item(pick == 0 ? i2cms_pkg::OP_EVENT : i2cms_pkg::OP_SUPPLY,
                              rand_word());
        CTX_BUSY:   send_item(pick == 0 ? i2cms_pkg::OP_BEGIN : i2cms_pkg::OP_SUPPLY,
                              rand_word());
        default:    send_item(pick == 0 ? i2cms_pkg::OP_BEGIN : i2cms_pkg::OP_EVENT,
                              rand_word());
      endcase
    end
    send_item(op, d);
  endtask

  // Engine completion; a wrong status outside a receive ends the transaction
  task automatic do_event(input logic [7:0] code, input bit is_start, input bit is_rx,
                          output bit aborted);
    logic [63:0] d;
    logic [7:0]  st;
    bit          bad;
    d   = rand_word();
    bad = ($urandom_range(99) < (is_rx ? rx_bad_pct : err_pct));
    if (bad) begin
      do st = 8'($urandom_range(255));
      while (((st & i2cms_pkg::STATUS_MASK) == code) ||
             (is_start && (st & i2cms_pkg::STATUS_MASK) == i2cms_pkg::ST_REP_START));
    end else begin
      st = (is_start && $urandom_range(1)) ? i2cms_pkg::ST_REP_START : code;
      st[2:0] = 3'($urandom_range(7));
    end
    d[41:34] = st;
    issue(i2cms_pkg::OP_EVENT, d, CTX_BUSY);
    aborted = bad && !is_rx;
  endtask

  // One transaction as the engine would answer it
  task automatic run_txn(input bit rd, input logic [1:0] rb, input logic [6:0] dev,
                         input logic [15:0] ra, input logic [7:0] cnt);
    logic [63:0] d;
    int          nreg;
    int          nrx;
    int          i;
    bit          ab;
    d = rand_word();
    d[0]     = rd;
    d[2:1]   = rb;
    d[9:3]   = dev;
    d[25:10] = ra;
    d[33:26] = cnt;
    issue(i2cms_pkg::OP_BEGIN, d, CTX_IDLE);
    nreg = (rb > 2'd2) ? 2 : rb;
    do_event(i2cms_pkg::ST_START, 1'b1, 1'b0, ab);
    if (ab) return;
    if (!(rd && nreg == 0)) begin
      do_event(i2cms_pkg::ST_SLA_W_ACK, 1'b0, 1'b0, ab);
      if (ab) return;
      for (i = 0; i < nreg; i++) begin
        do_event(i2cms_pkg::ST_DATA_TX_ACK, 1'b0, 1'b0, ab);
        if (ab) return;
      end
    end
    if (rd) begin
      if (nreg != 0) begin
        do_event(i2cms_pkg::ST_START, 1'b1, 1'b0, ab);
        if (ab) return;
      end
      do_event(i2cms_pkg::ST_SLA_R_ACK, 1'b0, 1'b0, ab);
      if (ab) return;
      nrx = (cnt == 8'd0) ? 1 : cnt;
      for (i = 0; i < nrx; i++) begin
        do_event((i == nrx - 1) ? i2cms_pkg::ST_DATA_RX_NACK : i2cms_pkg::ST_DATA_RX_ACK,
                 1'b0, 1'b1, ab);
      end
    end else begin
      for (i = 0; i < cnt; i++) begin
        issue(i2cms_pkg::OP_SUPPLY, rand_word(), CTX_SUPPLY);
        do_event(i2cms_pkg::ST_DATA_TX_ACK, 1'b0, 1'b0, ab);
        if (ab) return;
      end
    end
  endtask

  // Random transactions, mostly short, now and then a long one
  task automatic run_random_txns(input int target);
    logic [7:0] cnt;
    while (stim_items < target) begin
      if ($urandom_range(29) == 0) cnt = 8'($urandom_range(255));
      else cnt = 8'($urandom_range(4));
      run_txn(1'($urandom_range(1)), 2'($urandom_range(3)), 7'($urandom_range(127)),
              16'($urandom_range(16'hFFFF)), cnt);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: misplaced items while idle, then the corner transactions
    send_item(i2cms_pkg::OP_EVENT, rand_word());
    send_item(i2cms_pkg::OP_SUPPLY, rand_word());
    send_item(i2cms_pkg::OP_BAD, rand_word());
    run_txn(1'b0, 2'd3, 7'h7F, 16'hFFFF, 8'd1);
    run_txn(1'b1, 2'd0, 7'h00, 16'h0000, 8'd0);
    rx_bad_pct = 100;
    run_txn(1'b1, 2'd1, 7'h55, 16'h00A5, 8'd2);
    rx_bad_pct = 0;
    run_txn(1'b0, 2'd0, 7'h2A, 16'h5A5A, 8'd0);

    // Random: three idling profiles
    stim_items = 0;
    err_pct    = 4;
    rx_bad_pct = 10;
    noise_pct  = 6;
    src_idle_pct = 9;
    dst_idle_pct = 47;
    run_random_txns(383);
    src_idle_pct = 47;
    dst_idle_pct = 9;
    run_random_txns(766);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random_txns(1150);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for the pipeline
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
rtl/i2cms_pkg.sv
rtl/i2cms_front.sv
rtl/i2cms_fifo.sv
rtl/i2cms_back.sv
rtl/i2c_master_transaction_sequencer.sv
tb/i2cms_result_checker.sv
tb/tb_i2c_master_transaction_sequencer.sv
